@@ rtl/core/hswoc_pkg.sv @@
// ----------------------------------------------------------------------------
// hswoc_pkg: shared types and constants of the hashed record store.
// Holds the operation and status codes, record layout and controller states.
// ----------------------------------------------------------------------------
package hswoc_pkg;

  localparam int HomeBucketsDef   = 10;
  localparam int OverflowDepthDef = 64;

  localparam int NameW  = 160;
  localparam int EmailW = 240;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_STORED_HOME = 3'd0,
    ST_STORED_OVF  = 3'd1,
    ST_FOUND_HOME  = 3'd2,
    ST_FOUND_OVF   = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_OVF_FULL    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_HOME_RD,
    S_HOME_CHK,
    S_OVF_RD,
    S_OVF_CHK,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // capture the input word
    logic    hash_step;   // add one name byte into the bucket sum
    logic    home_read;   // read the home slot
    logic    ovf_read;    // read the overflow slot at the walk pointer
    logic    ovf_follow;  // move the walk pointer to the link just read
    logic    home_write;  // write a new record into the home slot
    logic    home_link;   // set the home slot's link to the new overflow slot
    logic    home_email;  // replace the email in the home slot
    logic    ovf_write;   // append a new record to the overflow area
    logic    ovf_link;    // set the link of the walked slot to the new slot
    logic    ovf_email;   // replace the email in the walked slot
    logic    result;      // drive a result word
    status_t st;
    logic    with_mail;
    logic    slot_ovf;    // report the walk pointer rather than the bucket
    logic    slot_new;    // report the newly allocated overflow slot
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  hash_done;
    logic  home_used;
    logic  home_empty_name;
    logic  home_match;
    logic  home_has_next;
    logic  ovf_full;
    logic  ovf_match;
    logic  ovf_has_next;
    logic  ovf_next_ok;
    logic  walk_ok;
  } sts_t;

endpackage

@@ rtl/core/hswoc_datapath.sv @@
// ----------------------------------------------------------------------------
// hswoc_datapath: record memories, bucket hash and chain walk registers.
// Performs what the controller commands.
// ----------------------------------------------------------------------------
module hswoc_datapath
  import hswoc_pkg::*;
#(
  parameter int HOME_BUCKETS   = HomeBucketsDef,
  parameter int OVERFLOW_DEPTH = OverflowDepthDef
) (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl,
  output sts_t          sts,
  input  logic [1:0]    func,
  input  logic [63:0]   name_low,
  input  logic [63:0]   name_mid,
  input  logic [31:0]   name_high,
  input  logic [63:0]   email_a,
  input  logic [63:0]   email_b,
  input  logic [63:0]   email_c,
  input  logic [47:0]   email_d,
  output logic          done,
  output logic [2:0]    status,
  output logic [5:0]    slot_index,
  output logic [63:0]   mail_a,
  output logic [63:0]   mail_b,
  output logic [63:0]   mail_c,
  output logic [47:0]   mail_d
);

  localparam int HW = (HOME_BUCKETS > 1) ? $clog2(HOME_BUCKETS) : 1;
  localparam int OW = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
  localparam int CW = $clog2(OVERFLOW_DEPTH + 1);
  localparam int SW = 13;  // holds twice the largest bucket count
  localparam int RW = NameW + EmailW + 1 + OW;

  // Record word: name, email, has-next flag, link.
  logic [RW-1:0] home_mem [HOME_BUCKETS];
  logic [RW-1:0] ovf_mem  [OVERFLOW_DEPTH];
  logic [HOME_BUCKETS-1:0] home_valid;

  logic [1:0]        func_q;
  logic [NameW-1:0]  name_raw;
  logic [NameW-1:0]  name_q;
  logic [EmailW-1:0] email_q;
  logic [4:0]        byte_cnt;
  logic              ended;
  logic [HW-1:0]     bucket;
  logic [SW-1:0]     sum;
  logic [RW-1:0]     home_rd;
  logic [RW-1:0]     ovf_rd;
  logic [OW-1:0]     walk;
  logic [CW-1:0]     steps;
  logic [CW-1:0]     ovf_count;

  logic [7:0]        cur_byte;
  logic              byte_zero;
  logic [SW-1:0]     sum_add;
  logic [RW-1:0]     new_rec;
  logic [OW-1:0]     new_slot;
  logic [SW-1:0]     byte_mod [256];

  function automatic logic [OW-1:0] home_rd_link(input logic [RW-1:0] r);
    return r[OW-1:0];
  endfunction

  assign cur_byte  = name_raw[8*byte_cnt +: 8];
  assign byte_zero = ended || (cur_byte == 8'd0);
  assign new_slot  = ovf_count[OW-1:0];
  assign new_rec   = {name_q, email_q, 1'b0, {OW{1'b0}}};

  // Each byte value already reduced modulo the bucket count.
  for (genvar b = 0; b < 256; b++) begin : g_byte_mod
    assign byte_mod[b] = SW'(b % HOME_BUCKETS);
  end

  // Running remainder: the reduced byte is added, then one conditional
  // subtract keeps the sum below the bucket count.
  always_comb begin
    sum_add = sum + (byte_zero ? SW'(0) : byte_mod[cur_byte]);
    if (sum_add >= SW'(HOME_BUCKETS)) sum_add = sum_add - SW'(HOME_BUCKETS);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_q   <= func;
      name_raw <= {name_high, name_mid, name_low};
      name_q   <= '0;
      email_q  <= {email_d, email_c, email_b, email_a};
      byte_cnt <= '0;
      ended    <= 1'b0;
      sum      <= '0;
    end
    if (ctl.hash_step) begin
      if (!byte_zero) name_q[8*byte_cnt +: 8] <= cur_byte;
      ended    <= byte_zero;
      sum      <= sum_add;
      byte_cnt <= byte_cnt + 5'd1;
      if (byte_cnt == 5'd19) bucket <= HW'(sum_add);
    end
    if (ctl.home_read) home_rd <= home_mem[bucket];
    if (ctl.ovf_read) begin
      ovf_rd <= ovf_mem[walk];
      steps  <= steps + CW'(1);
    end
    if (ctl.home_read) begin
      walk  <= home_rd_link(home_mem[bucket]);
      steps <= '0;
    end
    if (ctl.ovf_follow) walk <= ovf_rd[OW-1:0];
    if (ctl.home_write) home_mem[bucket] <= new_rec;
    if (ctl.home_link)
      home_mem[bucket] <= {home_rd[RW-1:OW+1], 1'b1, new_slot};
    if (ctl.home_email)
      home_mem[bucket] <= {home_rd[RW-1 -: NameW], email_q, home_rd[OW:0]};
    if (ctl.ovf_write) ovf_mem[new_slot] <= new_rec;
    if (ctl.ovf_link) ovf_mem[walk] <= {ovf_rd[RW-1:OW+1], 1'b1, new_slot};
    if (ctl.ovf_email)
      ovf_mem[walk] <= {ovf_rd[RW-1 -: NameW], email_q, ovf_rd[OW:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_valid <= '0;
      ovf_count  <= '0;
      done       <= 1'b0;
    end else begin
      done <= ctl.result;
      if (ctl.home_write) home_valid[bucket] <= 1'b1;
      if (ctl.ovf_write) ovf_count <= ovf_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result) begin
      status <= ctl.st;
      if (ctl.slot_new)      slot_index <= 6'(new_slot);
      else if (ctl.slot_ovf) slot_index <= 6'(walk);
      else                   slot_index <= 6'(bucket);
      // An update returns the new email, a look-up the stored one.
      if (!ctl.with_mail)
        {mail_d, mail_c, mail_b, mail_a} <= '0;
      else if (func_q == FUNC_UPDATE)
        {mail_d, mail_c, mail_b, mail_a} <= email_q;
      else if (ctl.slot_ovf)
        {mail_d, mail_c, mail_b, mail_a} <= ovf_rd[RW-NameW-1 -: EmailW];
      else
        {mail_d, mail_c, mail_b, mail_a} <= home_rd[RW-NameW-1 -: EmailW];
    end
  end

  always_comb begin
    sts.func            = func_t'(func_q);
    sts.hash_done       = (byte_cnt == 5'd19);
    sts.home_used       = home_valid[bucket];
    sts.home_empty_name = (home_rd[RW-NameW +: 8] == 8'd0);
    sts.home_match      = (home_rd[RW-1 -: NameW] == name_q);
    sts.home_has_next   = home_rd[OW];
    sts.ovf_full        = (ovf_count >= CW'(OVERFLOW_DEPTH));
    sts.ovf_match       = (ovf_rd[RW-1 -: NameW] == name_q);
    sts.ovf_has_next    = ovf_rd[OW];
    sts.ovf_next_ok     = (CW'(ovf_rd[OW-1:0]) < CW'(OVERFLOW_DEPTH));
    sts.walk_ok         = (steps < CW'(OVERFLOW_DEPTH));
  end

  // Record name sits at the top of the word; bytes are packed byte 0 low.
  // home_rd name field ordering matches new_rec, so compares are direct.

endmodule

@@ rtl/core/hswoc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hswoc_ctrl: sequencer for hashing, home slot check and chain walk.
// Issues one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module hswoc_ctrl
  import hswoc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;
  logic   inserting, inserting_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inserting <= 1'b0;
    end else begin
      state     <= state_next;
      inserting <= inserting_next;
    end
  end

  always_comb begin
    state_next     = state;
    inserting_next = inserting;
    ctl            = '0;
    ctl.st         = ST_NOT_FOUND;
    busy           = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        ctl.hash_step = 1'b1;
        if (sts.hash_done) state_next = S_HOME_RD;
      end
      S_HOME_RD: begin
        ctl.home_read = 1'b1;
        state_next    = S_HOME_CHK;
      end
      S_HOME_CHK: begin
        state_next = S_DONE;
        ctl.result = 1'b1;
        if (sts.func == FUNC_INSERT) begin
          if (!sts.home_used || sts.home_empty_name) begin
            ctl.home_write = 1'b1;
            ctl.st         = ST_STORED_HOME;
          end else if (sts.ovf_full) begin
            ctl.st = ST_OVF_FULL;
          end else if (!sts.home_has_next) begin
            ctl.ovf_write = 1'b1;
            ctl.home_link = 1'b1;
            ctl.st        = ST_STORED_OVF;
            ctl.slot_new  = 1'b1;
          end else begin
            ctl.result     = 1'b0;
            inserting_next = 1'b1;
            state_next     = S_OVF_RD;
          end
        end else if (sts.func == FUNC_NONE || !sts.home_used) begin
          ctl.st = ST_NOT_FOUND;
        end else if (sts.home_match) begin
          ctl.home_email = (sts.func == FUNC_UPDATE);
          ctl.st         = ST_FOUND_HOME;
          ctl.with_mail  = 1'b1;
        end else if (sts.home_has_next) begin
          ctl.result     = 1'b0;
          inserting_next = 1'b0;
          state_next     = S_OVF_RD;
        end
      end
      S_OVF_RD: begin
        ctl.ovf_read = 1'b1;
        state_next   = S_OVF_CHK;
      end
      S_OVF_CHK: begin
        if (inserting) begin
          if (sts.ovf_has_next && sts.ovf_next_ok && sts.walk_ok) begin
            ctl.ovf_follow = 1'b1;
            state_next     = S_OVF_RD;
          end else begin
            ctl.ovf_write = 1'b1;
            ctl.ovf_link  = 1'b1;
            ctl.result    = 1'b1;
            ctl.st        = ST_STORED_OVF;
            ctl.slot_new  = 1'b1;
            state_next    = S_DONE;
          end
        end else if (sts.ovf_match) begin
          ctl.ovf_email = (sts.func == FUNC_UPDATE);
          ctl.result    = 1'b1;
          ctl.st        = ST_FOUND_OVF;
          ctl.with_mail = 1'b1;
          ctl.slot_ovf  = 1'b1;
          state_next    = S_DONE;
        end else if (sts.ovf_has_next && sts.ovf_next_ok && sts.walk_ok) begin
          ctl.ovf_follow = 1'b1;
          state_next     = S_OVF_RD;
        end else begin
          ctl.result = 1'b1;
          ctl.st     = ST_NOT_FOUND;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/hashed_store_with_overflow_chain.sv @@
// ----------------------------------------------------------------------------
// hashed_store_with_overflow_chain: hashed name/email record store.
// Home buckets with a chained overflow area; insert, look up and update.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the single result word has been shown. The result appears on status,
// slot_index and mail_a..mail_d for exactly one cycle, marked by done, and
// must be captured then, since the receiver cannot hold it off. The block
// works on one word at a time. The name hash consumes one byte per cycle over
// every byte of the name field; the home slot is then read and checked, and
// every record visited on the overflow chain is read and checked in turn.
// After reset the home slots read as empty at once, with no clearing pass.
module hashed_store_with_overflow_chain
  import hswoc_pkg::*;
#(
  parameter int HOME_BUCKETS   = HomeBucketsDef,
  parameter int OVERFLOW_DEPTH = OverflowDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [63:0] name_low,
  input  logic [63:0] name_mid,
  input  logic [31:0] name_high,
  input  logic [63:0] email_a,
  input  logic [63:0] email_b,
  input  logic [63:0] email_c,
  input  logic [47:0] email_d,
  output logic        done,
  output logic [2:0]  status,
  output logic [5:0]  slot_index,
  output logic [63:0] mail_a,
  output logic [63:0] mail_b,
  output logic [63:0] mail_c,
  output logic [47:0] mail_d
);

  ctl_t ctl;
  sts_t sts;

  // The controller sequences every word; the datapath owns all storage.
  hswoc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  hswoc_datapath #(
    .HOME_BUCKETS   (HOME_BUCKETS),
    .OVERFLOW_DEPTH (OVERFLOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .func       (func),
    .name_low   (name_low),
    .name_mid   (name_mid),
    .name_high  (name_high),
    .email_a    (email_a),
    .email_b    (email_b),
    .email_c    (email_c),
    .email_d    (email_d),
    .done       (done),
    .status     (status),
    .slot_index (slot_index),
    .mail_a     (mail_a),
    .mail_b     (mail_b),
    .mail_c     (mail_c),
    .mail_d     (mail_d)
  );

endmodule

@@ rtl/core/hswoc_checker.sv @@
// ----------------------------------------------------------------------------
// hswoc_checker: port-level checks on the hashed record store.
// Watches the handshake and result words seen on the top level's ports.
// ----------------------------------------------------------------------------
module hswoc_checker
  import hswoc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [63:0] mail_a
);

  // An accepted word makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  // A result is only shown while a word is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result shown while idle");

  // Results are single-cycle strobes.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held longer than one cycle");

  // Status codes stay within the defined set.
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_OVF_FULL) else $error("undefined status code");

  // Home-slot stores and misses carry no mail on mail_a.
  a_mail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_STORED_HOME || status == ST_NOT_FOUND) |-> mail_a == 64'd0)
    else $error("mail present on a result without a record");

endmodule

bind hashed_store_with_overflow_chain hswoc_checker u_hswoc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .mail_a (mail_a)
);

@@ tb/sv/hashed_store_with_overflow_chain_tb.sv @@
// ----------------------------------------------------------------------------
// hashed_store_with_overflow_chain_tb: self-checking bench for the record store
// Drives insert, look-up and update words from a small pool of names so that
// chains grow and fill the overflow area. Every result word is compared with
// the bench's own model of the buckets, the overflow area and the chain links.
// ----------------------------------------------------------------------------
module hashed_store_with_overflow_chain_tb;
  import hswoc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBuckets  = HomeBucketsDef;
  localparam int NOverflow = OverflowDepthDef;
  localparam int PoolSize  = 20;
  localparam int StallLimit = 4000;

  typedef struct {
    status_t     st;
    logic [5:0]  slot;
    logic [239:0] mail;
  } outcome_t;

  // Model of the store plus the queue of result words still owed by the block.
  class store_scoreboard;
    logic [159:0] home_name [NBuckets];
    logic [239:0] home_mail [NBuckets];
    bit           home_used [NBuckets];
    bit           home_linked [NBuckets];
    int           home_next [NBuckets];
    logic [159:0] ovf_name [NOverflow];
    logic [239:0] ovf_mail [NOverflow];
    bit           ovf_linked [NOverflow];
    int           ovf_next [NOverflow];
    int           ovf_used;
    outcome_t     owed [$];
    int           errors;

    function new();
      for (int i = 0; i < NBuckets; i++) begin
        home_name[i] = '0; home_mail[i] = '0;
        home_used[i] = 0; home_linked[i] = 0; home_next[i] = 0;
      end
      for (int i = 0; i < NOverflow; i++) begin
        ovf_name[i] = '0; ovf_mail[i] = '0; ovf_linked[i] = 0; ovf_next[i] = 0;
      end
      ovf_used = 0;
      errors = 0;
    endfunction

    // Works out the result of one accepted word and updates the model.
    function void note_word(func_t fn, logic [159:0] raw, logic [239:0] mail_in);
      logic [159:0] nm;
      int sum, h, idx, steps;
      bit ended;
      outcome_t o;
      nm = '0; sum = 0; ended = 0;
      for (int i = 0; i < 20; i++) begin
        if (raw[8*i +: 8] == 8'd0) ended = 1;
        if (!ended) begin
          nm[8*i +: 8] = raw[8*i +: 8];
          sum += raw[8*i +: 8];
        end
      end
      h = sum % NBuckets;
      o.st = ST_NOT_FOUND; o.slot = h[5:0]; o.mail = '0;
      if (fn == FUNC_INSERT) begin
        if (!home_used[h] || home_name[h][7:0] == 8'd0) begin
          home_name[h] = nm; home_mail[h] = mail_in;
          home_used[h] = 1; home_linked[h] = 0;
          o.st = ST_STORED_HOME;
        end else if (ovf_used >= NOverflow) begin
          o.st = ST_OVF_FULL;
        end else begin
          ovf_name[ovf_used] = nm; ovf_mail[ovf_used] = mail_in;
          ovf_linked[ovf_used] = 0;
          if (!home_linked[h]) begin
            home_linked[h] = 1; home_next[h] = ovf_used;
          end else begin
            idx = home_next[h];
            for (steps = 0; steps < NOverflow && ovf_linked[idx]; steps++)
              idx = ovf_next[idx];
            ovf_linked[idx] = 1; ovf_next[idx] = ovf_used;
          end
          o.st = ST_STORED_OVF; o.slot = ovf_used[5:0];
          ovf_used++;
        end
      end else if (fn != FUNC_NONE && home_used[h]) begin
        if (home_name[h] == nm) begin
          if (fn == FUNC_UPDATE) home_mail[h] = mail_in;
          o.st = ST_FOUND_HOME; o.mail = home_mail[h];
        end else if (home_linked[h]) begin
          idx = home_next[h];
          for (steps = 0; steps < NOverflow; steps++) begin
            if (ovf_name[idx] == nm) begin
              if (fn == FUNC_UPDATE) ovf_mail[idx] = mail_in;
              o.st = ST_FOUND_OVF; o.slot = idx[5:0]; o.mail = ovf_mail[idx];
              break;
            end
            if (!ovf_linked[idx]) break;
            idx = ovf_next[idx];
          end
        end
      end
      owed.push_back(o);
    endfunction

    function void check_word(logic [2:0] st, logic [5:0] slot, logic [239:0] mail);
      outcome_t o;
      if (owed.size() == 0) begin
        $error("result word with nothing expected: status %0d slot %0d", st, slot);
        errors++;
        return;
      end
      o = owed.pop_front();
      if (st !== o.st) begin
        $error("status: expected %0d, got %0d", o.st, st); errors++;
      end
      if (slot !== o.slot) begin
        $error("slot_index: expected %0d, got %0d", o.slot, slot); errors++;
      end
      if (mail[63:0] !== o.mail[63:0]) begin
        $error("mail_a: expected %h, got %h", o.mail[63:0], mail[63:0]); errors++;
      end
      if (mail[127:64] !== o.mail[127:64]) begin
        $error("mail_b: expected %h, got %h", o.mail[127:64], mail[127:64]); errors++;
      end
      if (mail[191:128] !== o.mail[191:128]) begin
        $error("mail_c: expected %h, got %h", o.mail[191:128], mail[191:128]); errors++;
      end
      if (mail[239:192] !== o.mail[239:192]) begin
        $error("mail_d: expected %h, got %h", o.mail[239:192], mail[239:192]); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy, done;
  logic [1:0]  func = FUNC_NONE;
  logic [63:0] name_low = '0, name_mid = '0;
  logic [31:0] name_high = '0;
  logic [63:0] email_a = '0, email_b = '0, email_c = '0;
  logic [47:0] email_d = '0;
  logic [2:0]  status;
  logic [5:0]  slot_index;
  logic [63:0] mail_a, mail_b, mail_c;
  logic [47:0] mail_d;

  store_scoreboard sb = new();
  logic [159:0] pool [PoolSize];
  int           pool_len [PoolSize];
  int           idle_pct;
  int           quiet_cycles = 0;

  always #2 clk = ~clk;

  hashed_store_with_overflow_chain dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .name_low(name_low), .name_mid(name_mid), .name_high(name_high),
    .email_a(email_a), .email_b(email_b), .email_c(email_c), .email_d(email_d),
    .done(done), .status(status), .slot_index(slot_index),
    .mail_a(mail_a), .mail_b(mail_b), .mail_c(mail_c), .mail_d(mail_d)
  );

  // Both monitors see the values from before the edge, since every driver
  // and the block itself update through nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_word(func_t'(func), {name_high, name_mid, name_low},
                   {email_d, email_c, email_b, email_a});
    if (!rst && done)
      sb.check_word(status, slot_index, {mail_d, mail_c, mail_b, mail_a});
  end

  // Watchdog: a long stretch with neither a word taken nor a result shown
  // means the block has hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [239:0] rand_mail();
    return 240'({rand64(), rand64(), rand64(), rand64()});
  endfunction

  // A pool name of the given length; the bytes after its terminating zero are
  // junk, which the block must ignore both when hashing and when comparing.
  function automatic logic [159:0] dress_name(logic [159:0] nm, int len);
    logic [159:0] r;
    r = 160'({rand64(), rand64(), rand64()});
    for (int i = 0; i < 20; i++)
      if (i < len) r[8*i +: 8] = nm[8*i +: 8];
      else if (i == len) r[8*i +: 8] = 8'd0;
    return r;
  endfunction

  // Offers one word from a rising edge and waits for the edge that takes it;
  // start stays high for back-to-back words, or drops by chance of idle_pct.
  task automatic send_word(func_t fn, logic [159:0] nm, logic [239:0] ml);
    start <= 1'b1;
    func <= fn;
    {name_high, name_mid, name_low} <= nm;
    {email_d, email_c, email_b, email_a} <= ml;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_pool(func_t fn, int k);
    send_word(fn, dress_name(pool[k], pool_len[k]), rand_mail());
  endtask

  // Holds the sender back until the block owes no more results.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.owed.size() != 0);
  endtask

  task automatic random_phase(int count);
    func_t fn;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      fn = r < 25 ? FUNC_INSERT : r < 60 ? FUNC_LOOKUP : r < 95 ? FUNC_UPDATE : FUNC_NONE;
      if ($urandom_range(99) < 85)
        send_pool(fn, $urandom_range(PoolSize - 1));
      else
        send_word(fn, 160'({rand64(), rand64(), rand64()}), rand_mail());
    end
  endtask

  initial begin
    // Pool of names with a spread of lengths, including the full twenty
    // bytes and the empty name.
    for (int k = 0; k < PoolSize; k++) begin
      pool_len[k] = (k == 0) ? 0 : (k == 1) ? 20 : $urandom_range(20, 1);
      pool[k] = '0;
      for (int i = 0; i < 20; i++) pool[k][8*i +: 8] = 8'($urandom_range(255, 1));
    end
    pool[1] = '1;

    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Look-ups and updates against untouched buckets first.
    send_pool(FUNC_LOOKUP, 2);
    send_pool(FUNC_UPDATE, 3);
    send_pool(FUNC_NONE, 2);
    // Extremes of the name: every byte all ones, and the empty name.
    send_word(FUNC_INSERT, '1, '1);
    send_word(FUNC_LOOKUP, '1, '0);
    send_word(FUNC_INSERT, '0, '0);
    send_pool(FUNC_LOOKUP, 0);
    // A second empty-name insert also goes to the overflow chain, since the home
    // slot of its bucket holds the all-ones name.
    send_pool(FUNC_INSERT, 0);
    send_pool(FUNC_UPDATE, 0);
    // Same name twice more: both go to the overflow chain of one bucket.
    send_word(FUNC_INSERT, '1, rand_mail());
    send_word(FUNC_INSERT, '1, rand_mail());
    send_pool(FUNC_INSERT, 4);
    send_pool(FUNC_INSERT, 4);
    send_pool(FUNC_INSERT, 4);
    send_pool(FUNC_LOOKUP, 4);
    send_pool(FUNC_UPDATE, 4);
    send_word(FUNC_UPDATE, '1, '1);
    send_word(FUNC_LOOKUP, '1, '0);
    send_pool(FUNC_NONE, 4);
    send_pool(FUNC_LOOKUP, 5);
    drain();

    // Random part in phases of sender idling; the second and the last end in a drain.
    idle_pct = 0;  random_phase(300);
    idle_pct = 59; random_phase(250);
    drain();
    idle_pct = 0;  random_phase(200);
    idle_pct = 7;  random_phase(250);
    start <= 1'b0;

    do @(posedge clk); while (sb.owed.size() != 0);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
